[src/image_conv3x3_shift_saturate_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 convolution block
// Concurrent checks clocked on the rising edge and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef IMAGE_CONV3X3_SHIFT_SATURATE_TOP_MACROS_SVH
`define IMAGE_CONV3X3_SHIFT_SATURATE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property holds at every edge outside reset
`define IMCONV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define IMCONV_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  `IMCONV_ASSERT(lbl, clk, rst_n, (pre) |=> (post), msg)

`else

`define IMCONV_ASSERT(lbl, clk, rst_n, prop, msg)
`define IMCONV_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

[src/imconv_pkg.sv]
// ----------------------------------------------------------------------------
// imconv_pkg
// Frame geometry, widths, register map and shared types of the convolution.
// ----------------------------------------------------------------------------
`default_nettype none

package imconv_pkg;

  localparam int FRAME_WIDTH  = 512;
  localparam int FRAME_HEIGHT = 512;

  localparam int COL_W   = $clog2(FRAME_WIDTH);
  localparam int ROW_W   = $clog2(FRAME_HEIGHT);
  localparam int PIX_W   = 8;
  localparam int COEF_W  = 8;
  localparam int PROD_W  = 17;
  localparam int SUM_W   = 20;
  localparam int SHIFT_W = 5;
  localparam int KROW_W  = 3 * COEF_W;
  localparam int TAPS    = 9;
  localparam int APB_DW  = 32;
  localparam int APB_AW  = 4;

  localparam logic [PIX_W-1:0]   PIX_MAX       = 8'hFF;
  localparam logic [KROW_W-1:0]  KTOP_RST      = 24'h010201;
  localparam logic [KROW_W-1:0]  KMID_RST      = 24'h020402;
  localparam logic [KROW_W-1:0]  KBOT_RST      = 24'h010201;
  localparam logic [SHIFT_W-1:0] SHIFT_RST     = 5'd4;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [1:0] {
    REG_KTOP  = 2'd0,
    REG_KMID  = 2'd1,
    REG_KBOT  = 2'd2,
    REG_SHIFT = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [KROW_W-1:0]  ktop;
    logic [KROW_W-1:0]  kmid;
    logic [KROW_W-1:0]  kbot;
    logic [SHIFT_W-1:0] shift;
  } cfg_t;

  // One pixel with the two pixels above it, leaving the line buffer
  typedef struct packed {
    logic valid;
    pix_t pix;
    pix_t up1;
    pix_t up2;
    logic emit;
    logic last;
  } tap_t;

endpackage

`default_nettype wire

[src/imconv_pix_if.sv]
// ----------------------------------------------------------------------------
// imconv_pix_if
// Input pixel channel: valid/ready with pixel and frame start flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface imconv_pix_if;
  import imconv_pkg::*;

  logic                valid;
  logic                ready;
  logic [PIX_W-1:0]    pixel_in;
  logic                frame_start;

  modport source (output valid, output pixel_in, output frame_start, input ready);
  modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

`default_nettype wire

[src/imconv_res_if.sv]
// ----------------------------------------------------------------------------
// imconv_res_if
// Result channel: valid/ready with filtered pixel and frame end flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface imconv_res_if;
  import imconv_pkg::*;

  logic                valid;
  logic                ready;
  logic [PIX_W-1:0]    pixel_out;
  logic                frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

`default_nettype wire

[src/image_conv3x3_shift_saturate_top.sv]
// ----------------------------------------------------------------------------
// image_conv3x3_shift_saturate_top
// 3x3 convolution of a grey pixel stream with shift and saturation.
// ----------------------------------------------------------------------------
// Takes one 8-bit pixel per clock in raster order and gives one result per
// interior pixel; border pixels give none. A pixel's result reaches the output
// register through the line memory read, window, products, sum, and shift
// and clamp, and the pipeline sustains one pixel per cycle, set by the single
// write and read of each line memory per pixel. A result held by a low ready
// stalls the whole pipeline. The line memories need no clearing after reset:
// the first two rows of each frame never produce a result.
`default_nettype none

module image_conv3x3_shift_saturate_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  imconv_pix_if.sink                         pix_i,
  imconv_res_if.source                       res_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [imconv_pkg::APB_AW-1:0] paddr,
  input  wire logic [imconv_pkg::APB_DW-1:0] pwdata,
  output logic      [imconv_pkg::APB_DW-1:0] prdata,
  output logic                               pready
);
  import imconv_pkg::*;

  cfg_t cfg;
  tap_t tap;
  logic adv;

  imconv_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  imconv_linebuf u_linebuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .pix_i  (pix_i),
    .tap_o  (tap)
  );

  imconv_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .tap_i  (tap),
    .adv_o  (adv),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire

[src/imconv_regs.sv]
// ----------------------------------------------------------------------------
// imconv_regs
// APB register file holding the three kernel rows and the shift amount.
// ----------------------------------------------------------------------------
`default_nettype none

module imconv_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [imconv_pkg::APB_AW-1:0] paddr,
  input  wire logic [imconv_pkg::APB_DW-1:0] pwdata,
  output logic      [imconv_pkg::APB_DW-1:0] prdata,
  output logic                               pready,
  output imconv_pkg::cfg_t                   cfg_o
);
  import imconv_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ktop  <= KTOP_RST;
      cfg_q.kmid  <= KMID_RST;
      cfg_q.kbot  <= KBOT_RST;
      cfg_q.shift <= SHIFT_RST;
    end else if (wr_en) begin
      case (idx)
        REG_KTOP:  cfg_q.ktop  <= pwdata[KROW_W-1:0];
        REG_KMID:  cfg_q.kmid  <= pwdata[KROW_W-1:0];
        REG_KBOT:  cfg_q.kbot  <= pwdata[KROW_W-1:0];
        REG_SHIFT: cfg_q.shift <= pwdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KTOP:  prdata = APB_DW'(cfg_q.ktop);
      REG_KMID:  prdata = APB_DW'(cfg_q.kmid);
      REG_KBOT:  prdata = APB_DW'(cfg_q.kbot);
      REG_SHIFT: prdata = APB_DW'(cfg_q.shift);
      default:   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[src/imconv_linebuf.sv]
// ----------------------------------------------------------------------------
// imconv_linebuf
// Raster position counters and two line memories giving the pixels above.
// ----------------------------------------------------------------------------
`default_nettype none

`include "image_conv3x3_shift_saturate_top_macros.svh"

module imconv_linebuf (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        adv_i,
  imconv_pix_if.sink       pix_i,
  output imconv_pkg::tap_t tap_o
);
  import imconv_pkg::*;

  // previous row and the row before it, one entry per column
  pix_t mem1 [FRAME_WIDTH];
  pix_t mem2 [FRAME_WIDTH];

  logic [COL_W-1:0] cnt_col_q, cnt_col_d, col_cur;
  logic [ROW_W-1:0] cnt_row_q, cnt_row_d, row_cur;
  logic             acc, fwd, col_wrap, emit_d, last_d;

  logic             s1_valid_q;
  logic [COL_W-1:0] tap_col_q;
  pix_t             pix_q, rd1_q, rd2_q;
  logic             emit_q, last_q;

  assign pix_i.ready = adv_i;
  assign acc         = pix_i.valid && adv_i;

  assign col_cur  = pix_i.frame_start ? '0 : cnt_col_q;
  assign row_cur  = pix_i.frame_start ? '0 : cnt_row_q;
  assign col_wrap = (col_cur == COL_W'(FRAME_WIDTH - 1));
  assign emit_d   = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
  assign last_d   = (row_cur == ROW_W'(FRAME_HEIGHT - 1)) && col_wrap;

  // pending write of the item ahead hits the column being read
  assign fwd = s1_valid_q && (tap_col_q == col_cur);

  always_comb begin
    cnt_col_d = col_wrap ? '0 : col_cur + COL_W'(1);
    cnt_row_d = row_cur;
    if (col_wrap) begin
      cnt_row_d = (row_cur == ROW_W'(FRAME_HEIGHT - 1)) ? '0 : row_cur + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_col_q  <= '0;
      cnt_row_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        cnt_col_q <= cnt_col_d;
        cnt_row_q <= cnt_row_d;
      end
      if (adv_i) begin
        s1_valid_q <= pix_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      pix_q     <= pix_i.pixel_in;
      tap_col_q <= col_cur;
      emit_q    <= emit_d;
      last_q    <= last_d;
      rd1_q     <= fwd ? pix_q : mem1[col_cur];
      rd2_q     <= fwd ? rd1_q : mem2[col_cur];
    end
    if (adv_i && s1_valid_q) begin
      mem1[tap_col_q] <= pix_q;
      mem2[tap_col_q] <= rd1_q;
    end
  end

  assign tap_o.valid = s1_valid_q;
  assign tap_o.pix   = pix_q;
  assign tap_o.up1   = rd1_q;
  assign tap_o.up2   = rd2_q;
  assign tap_o.emit  = emit_q;
  assign tap_o.last  = last_q;

  `IMCONV_ASSERT(a_col_range, clk_i, rst_ni, cnt_col_q <= COL_W'(FRAME_WIDTH - 1),
                 "column counter beyond frame width")
  `IMCONV_ASSERT_NEXT(a_start_origin, clk_i, rst_ni, acc && pix_i.frame_start,
                      tap_col_q == '0 && !emit_q, "frame start not placed at origin")

endmodule

`default_nettype wire

[src/imconv_mac.sv]
// ----------------------------------------------------------------------------
// imconv_mac
// 3x3 window, kernel products, sum, shift and clamp, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "image_conv3x3_shift_saturate_top_macros.svh"

module imconv_mac (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  imconv_pkg::cfg_t cfg_i,
  input  imconv_pkg::tap_t tap_i,
  output logic             adv_o,
  imconv_res_if.source     res_o
);
  import imconv_pkg::*;

  pix_t                     win_q [3][3];
  logic [KROW_W-1:0]        krow [3];
  logic signed [PROD_W-1:0] prod_d [TAPS];
  logic signed [PROD_W-1:0] prod_q [TAPS];
  logic signed [SUM_W-1:0]  sum_d, sum_q;
  logic [SUM_W-2:0]         mag;
  pix_t                     sat_d, res_pix_q;
  logic                     va_q, la_q, vb_q, lb_q, vc_q, lc_q;
  logic                     res_valid_q, res_last_q;

  // the whole pipe moves unless a result is held
  assign adv_o = !res_valid_q || res_o.ready;

  assign krow[0] = cfg_i.ktop;
  assign krow[1] = cfg_i.kmid;
  assign krow[2] = cfg_i.kbot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          win_q[y][x] <= '0;
        end
      end
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else if (adv_o) begin
      if (tap_i.valid) begin
        for (int y = 0; y < 3; y++) begin
          win_q[y][0] <= win_q[y][1];
          win_q[y][1] <= win_q[y][2];
        end
        win_q[0][2] <= tap_i.up2;
        win_q[1][2] <= tap_i.up1;
        win_q[2][2] <= tap_i.pix;
      end
      va_q        <= tap_i.valid && tap_i.emit;
      vb_q        <= va_q;
      vc_q        <= vb_q;
      res_valid_q <= vc_q;
    end
  end

  always_comb begin
    for (int y = 0; y < 3; y++) begin
      for (int x = 0; x < 3; x++) begin
        prod_d[y*3 + x] = $signed({1'b0, win_q[y][x]})
                        * $signed(krow[y][x*COEF_W +: COEF_W]);
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < TAPS; i++) begin
      sum_d = sum_d + SUM_W'(prod_q[i]);
    end
  end

  // negative sums clamp to zero, large ones to full scale
  always_comb begin
    mag = sum_q[SUM_W-2:0] >> cfg_i.shift;
    if (sum_q[SUM_W-1]) begin
      sat_d = '0;
    end else if (|mag[SUM_W-2:PIX_W]) begin
      sat_d = PIX_MAX;
    end else begin
      sat_d = mag[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      la_q       <= tap_i.last;
      prod_q     <= prod_d;
      lb_q       <= la_q;
      sum_q      <= sum_d;
      lc_q       <= lb_q;
      res_pix_q  <= sat_d;
      res_last_q <= lc_q;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.pixel_out = res_pix_q;
  assign res_o.frame_end = res_last_q;

  `IMCONV_ASSERT_NEXT(a_sum_reaches_out, clk_i, rst_ni, adv_o && vc_q, res_valid_q,
                      "summed item did not reach the result register")
  `IMCONV_ASSERT_NEXT(a_window_shift, clk_i, rst_ni, adv_o && tap_i.valid,
                      win_q[2][1] == $past(win_q[2][2]), "window did not shift")

endmodule

`default_nettype wire
